/* hw/rtl/ssdmd_pkg.sv */
package ssdmd_pkg;

    localparam int PIX_W  = 8;
    localparam int EDGE_W = 5;
    localparam int SUB_W  = 4;
    localparam int SQ_W   = 16;
    localparam int SUM_W  = 24;
    localparam int THR_W  = 17;

    localparam logic [1:0] ST_QUIET   = 2'd0;
    localparam logic [1:0] ST_CHANGED = 2'd1;
    localparam logic [1:0] ST_ALARM   = 2'd2;
    localparam logic [1:0] ST_FAULT   = 2'd3;

    localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_SENSITIVITY  = 2'd3;

    localparam logic [1:0] SENS_LOW  = 2'd1;
    localparam logic [1:0] SENS_MID  = 2'd2;
    localparam logic [1:0] SENS_HIGH = 2'd3;

    localparam logic [4:0] RST_BLOCK_SIZE   = 5'd8;
    localparam logic [7:0] RST_FRAME_WIDTH  = 8'd160;
    localparam logic [7:0] RST_FRAME_HEIGHT = 8'd120;
    localparam logic [1:0] RST_SENSITIVITY  = SENS_MID;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
    } t_in;

    typedef struct packed {
        logic [5:0]       block_col;
        logic [7:0]       block_row;
        logic [SUM_W-1:0] block_sum;
        logic [1:0]       status;
        logic             last_block;
    } t_out;

    // per-beat tile position info from the position tracker
    typedef struct packed {
        logic [7:0] bc;
        logic [7:0] br;
        logic       inb;
        logic       first;
        logic       last;
        logic       last_block;
        logic       frame_end;
    } t_item;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_len;
        logic [1:0]        sens;
        logic              busy;
    } t_cfg_view;

    function automatic logic [EDGE_W-1:0] tile_edge(input logic [EDGE_W-1:0] bs);
        logic [EDGE_W-1:0] e;
        if (bs == '0) begin
            e = EDGE_W'(1);
        end else if (bs > EDGE_W'(16)) begin
            e = EDGE_W'(16);
        end else begin
            e = bs;
        end
        return e;
    endfunction

    function automatic logic [THR_W-1:0] edge_pow4(input logic [EDGE_W-1:0] e);
        logic [THR_W-1:0] t;
        case (e)
            5'd2:    t = 17'd16;
            5'd3:    t = 17'd81;
            5'd4:    t = 17'd256;
            5'd5:    t = 17'd625;
            5'd6:    t = 17'd1296;
            5'd7:    t = 17'd2401;
            5'd8:    t = 17'd4096;
            5'd9:    t = 17'd6561;
            5'd10:   t = 17'd10000;
            5'd11:   t = 17'd14641;
            5'd12:   t = 17'd20736;
            5'd13:   t = 17'd28561;
            5'd14:   t = 17'd38416;
            5'd15:   t = 17'd50625;
            5'd16:   t = 17'd65536;
            default: t = 17'd1;
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/ssdmd_ram.sv */
module ssdmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ssdmd_div.sv */
module ssdmd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [7:0]                     i_dividend,
    input  logic [ssdmd_pkg::EDGE_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [7:0]                     o_quot,
    output logic [ssdmd_pkg::SUB_W-1:0]    o_rem
);

    // restoring divide, one quotient bit per cycle
    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_quot;
    logic [ssdmd_pkg::EDGE_W-1:0] r_rem;

    logic [ssdmd_pkg::EDGE_W-1:0] w_shift;
    logic                         w_ge;

    assign w_shift = {r_rem[ssdmd_pkg::SUB_W-1:0], r_quot[7]};
    assign w_ge    = (w_shift >= i_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[6:0], w_ge};
            r_rem  <= w_ge ? (w_shift - i_divisor) : w_shift;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[ssdmd_pkg::SUB_W-1:0];

endmodule

/* hw/rtl/ssdmd_pos.sv */
module ssdmd_pos #(
    parameter int MAX_BLOCK_COLS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_accept,
    output ssdmd_pkg::t_item       o_item,
    output ssdmd_pkg::t_cfg_view   o_view
);

    localparam logic [7:0] MAX_COLS = 8'(MAX_BLOCK_COLS);

    logic [ssdmd_pkg::EDGE_W-1:0] r_block_size;
    logic [7:0]                   r_frame_width;
    logic [7:0]                   r_frame_height;
    logic [1:0]                   r_sens;

    logic [7:0] r_col, r_row, r_bc, r_br, r_wn, r_hn;
    logic [ssdmd_pkg::SUB_W-1:0] r_sc, r_sr;
    logic [7:0] n_col, n_row, n_bc, n_br;
    logic [ssdmd_pkg::SUB_W-1:0] n_sc, n_sr;

    logic       r_busy;
    logic       r_start;
    logic [1:0] r_step;

    logic [ssdmd_pkg::EDGE_W-1:0] w_edge;
    logic [ssdmd_pkg::SUB_W-1:0]  w_edge_m1;
    logic                         w_col_wrap, w_row_wrap;
    logic [7:0]                   w_dividend;
    logic                         w_div_done;
    logic [7:0]                   w_quot;
    logic [ssdmd_pkg::SUB_W-1:0]  w_rem;

    assign w_edge     = ssdmd_pkg::tile_edge(r_block_size);
    assign w_edge_m1  = ssdmd_pkg::SUB_W'(w_edge - ssdmd_pkg::EDGE_W'(1));
    assign w_col_wrap = ({1'b0, r_col} + 9'd1) >= {1'b0, r_frame_width};
    assign w_row_wrap = ({1'b0, r_row} + 9'd1) >= {1'b0, r_frame_height};

    always_comb begin
        case (r_step)
            2'd0:    w_dividend = r_col;
            2'd1:    w_dividend = r_row;
            2'd2:    w_dividend = r_frame_width;
            default: w_dividend = r_frame_height;
        endcase
    end

    ssdmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_edge),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_bc  = r_bc;
        n_br  = r_br;
        n_sc  = r_sc;
        n_sr  = r_sr;
        if (w_col_wrap) begin
            n_col = '0;
            n_bc  = '0;
            n_sc  = '0;
            if (w_row_wrap) begin
                n_row = '0;
                n_br  = '0;
                n_sr  = '0;
            end else begin
                n_row = r_row + 8'd1;
                if (r_sr == w_edge_m1) begin
                    n_sr = '0;
                    n_br = r_br + 8'd1;
                end else begin
                    n_sr = r_sr + ssdmd_pkg::SUB_W'(1);
                end
            end
        end else begin
            n_col = r_col + 8'd1;
            if (r_sc == w_edge_m1) begin
                n_sc = '0;
                n_bc = r_bc + 8'd1;
            end else begin
                n_sc = r_sc + ssdmd_pkg::SUB_W'(1);
            end
        end
    end

    // any config write re-derives tile position and tile counts: 4 divides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= ssdmd_pkg::RST_BLOCK_SIZE;
            r_frame_width  <= ssdmd_pkg::RST_FRAME_WIDTH;
            r_frame_height <= ssdmd_pkg::RST_FRAME_HEIGHT;
            r_sens         <= ssdmd_pkg::RST_SENSITIVITY;
            r_col          <= '0;
            r_row          <= '0;
            r_bc           <= '0;
            r_br           <= '0;
            r_sc           <= '0;
            r_sr           <= '0;
            r_wn           <= '0;
            r_hn           <= '0;
            r_busy         <= 1'b1;
            r_start        <= 1'b1;
            r_step         <= 2'd0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ssdmd_pkg::CFG_BLOCK_SIZE:   r_block_size   <= i_cfg_data[4:0];
                    ssdmd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    ssdmd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    ssdmd_pkg::CFG_SENSITIVITY:  r_sens         <= i_cfg_data[1:0];
                    default: ;
                endcase
                r_busy  <= 1'b1;
                r_start <= 1'b1;
                r_step  <= 2'd0;
            end else if (w_div_done && !r_start) begin
                unique case (r_step)
                    2'd0: begin
                        r_bc <= w_quot;
                        r_sc <= w_rem;
                    end
                    2'd1: begin
                        r_br <= w_quot;
                        r_sr <= w_rem;
                    end
                    2'd2: r_wn <= (w_quot > MAX_COLS) ? MAX_COLS : w_quot;
                    default: r_hn <= w_quot;
                endcase
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step  <= r_step + 2'd1;
                    r_start <= 1'b1;
                end
            end else if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_bc  <= n_bc;
                r_br  <= n_br;
                r_sc  <= n_sc;
                r_sr  <= n_sr;
            end
        end
    end

    assign o_item.bc         = r_bc;
    assign o_item.br         = r_br;
    assign o_item.inb        = (r_bc < r_wn) && (r_br < r_hn);
    assign o_item.first      = (r_sc == '0) && (r_sr == '0);
    assign o_item.last       = (r_sc == w_edge_m1) && (r_sr == w_edge_m1);
    assign o_item.last_block = (r_bc == r_wn - 8'd1) && (r_br == r_hn - 8'd1);
    assign o_item.frame_end  = w_col_wrap && w_row_wrap;

    assign o_view.edge_len = w_edge;
    assign o_view.sens     = r_sens;
    assign o_view.busy     = r_busy;

endmodule

/* hw/rtl/block_ssd_motion_detector_top.sv */
// Block motion detector. Takes one pixel pair per clock in raster order while
// ready is high and sums squared differences per block_size x block_size tile,
// one running sum per tile column held in a single-port-write RAM of
// MAX_BLOCK_COLS entries. Stage 1 reads the column sum and adds the new square,
// stage 2 rates the tile, so a tile's sum and status are offered from stage 2
// once its bottom-right pixel has passed through stage 1; a same-column
// write/read in back-to-back beats is forwarded. After reset and after every
// config write, ready stays low while a bit-serial divider re-derives the tile
// position and tile counts (four divides of eight quotient bits each).
module block_ssd_motion_detector_top #(
    parameter int MAX_BLOCK_COLS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssdmd_pkg::t_in      i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssdmd_pkg::t_out     o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    localparam int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;

    ssdmd_pkg::t_item     w_item;
    ssdmd_pkg::t_cfg_view w_view;

    logic w_accept, w_s1_adv, w_s1_free, w_s2_free, w_s2_drain, w_emit;

    // stage 1: tile sum read-modify-write
    logic                           r_s1_valid;
    logic [ssdmd_pkg::SQ_W-1:0]     r_s1_sq;
    ssdmd_pkg::t_item               r_s1_item;
    logic                           r_s1_fwd;
    logic [ssdmd_pkg::SUM_W-1:0]    r_s1_fwd_data;
    logic [ssdmd_pkg::SUM_W-1:0]    w_ram_rdata, w_s1_base, w_s1_sum;
    logic                           w_ram_we;

    // stage 2: rating and output
    logic                           r_s2_valid;
    logic [ssdmd_pkg::SUM_W-1:0]    r_s2_sum;
    logic [7:0]                     r_s2_bc, r_s2_br;
    logic                           r_s2_cand, r_s2_lastblk, r_s2_frame_end;
    logic                           r_alarm;

    logic [ssdmd_pkg::PIX_W-1:0]    w_diff;
    logic [ssdmd_pkg::SQ_W-1:0]     w_sq;
    logic [ssdmd_pkg::THR_W-1:0]    w_thr;
    logic [ssdmd_pkg::SUM_W+1:0]    w_sum4, w_lvl25, w_lvl49;
    logic [ssdmd_pkg::SUM_W-1:0]    w_lvl9;
    logic                           w_over, w_hit;
    logic [1:0]                     w_status;

    ssdmd_pos #(
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .o_item     (w_item),
        .o_view     (w_view)
    );

    assign w_emit     = r_s2_valid && r_s2_cand && !r_alarm;
    assign w_s2_drain = r_s2_valid && (!w_emit || i_out_ready);
    assign w_s2_free  = !r_s2_valid || w_s2_drain;
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s1_adv;
    assign o_in_ready = w_s1_free && !w_view.busy;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_diff = (i_in.pixel_a >= i_in.pixel_b) ? (i_in.pixel_a - i_in.pixel_b)
                                                   : (i_in.pixel_b - i_in.pixel_a);
    assign w_sq   = ssdmd_pkg::SQ_W'(w_diff) * ssdmd_pkg::SQ_W'(w_diff);

    assign w_s1_base = r_s1_fwd ? r_s1_fwd_data : w_ram_rdata;
    assign w_s1_sum  = r_s1_item.first ? {8'd0, r_s1_sq}
                                       : (w_s1_base + {8'd0, r_s1_sq});
    assign w_ram_we  = w_s1_adv && r_s1_item.inb;
    assign w_hit     = w_ram_we && (r_s1_item.bc == w_item.bc);

    ssdmd_ram #(
        .WIDTH (ssdmd_pkg::SUM_W),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s1_item.bc[AW-1:0]),
        .i_wdata (w_s1_sum),
        .i_re    (w_accept),
        .i_raddr (w_item.bc[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sq       <= w_sq;
            r_s1_item     <= w_item;
            r_s1_fwd      <= w_hit;
            r_s1_fwd_data <= w_s1_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_alarm    <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_drain) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_drain) begin
                if (r_s2_frame_end) begin
                    r_alarm <= 1'b0;
                end else if (w_emit && (w_status == ssdmd_pkg::ST_ALARM ||
                                        w_status == ssdmd_pkg::ST_FAULT)) begin
                    r_alarm <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_sum       <= w_s1_sum;
            r_s2_bc        <= r_s1_item.bc;
            r_s2_br        <= r_s1_item.br;
            r_s2_cand      <= r_s1_item.inb && r_s1_item.last;
            r_s2_lastblk   <= r_s1_item.last_block;
            r_s2_frame_end <= r_s1_item.frame_end;
        end
    end

    // 6.25x and 12.25x compare as 4*sum against 25*T and 49*T
    assign w_thr   = ssdmd_pkg::edge_pow4(w_view.edge_len);
    assign w_sum4  = {r_s2_sum, 2'b00};
    assign w_lvl25 = (ssdmd_pkg::SUM_W+2)'(w_thr) * (ssdmd_pkg::SUM_W+2)'(25);
    assign w_lvl49 = (ssdmd_pkg::SUM_W+2)'(w_thr) * (ssdmd_pkg::SUM_W+2)'(49);
    assign w_lvl9  = ssdmd_pkg::SUM_W'(w_thr) * ssdmd_pkg::SUM_W'(9);
    assign w_over  = r_s2_sum > ssdmd_pkg::SUM_W'(w_thr);

    always_comb begin
        if (!w_over) begin
            w_status = ssdmd_pkg::ST_QUIET;
        end else begin
            case (w_view.sens)
                ssdmd_pkg::SENS_LOW:
                    w_status = (w_sum4 > w_lvl25) ? ssdmd_pkg::ST_ALARM : ssdmd_pkg::ST_CHANGED;
                ssdmd_pkg::SENS_MID:
                    w_status = (r_s2_sum > w_lvl9) ? ssdmd_pkg::ST_ALARM : ssdmd_pkg::ST_CHANGED;
                ssdmd_pkg::SENS_HIGH:
                    w_status = (w_sum4 > w_lvl49) ? ssdmd_pkg::ST_ALARM : ssdmd_pkg::ST_CHANGED;
                default:
                    w_status = ssdmd_pkg::ST_FAULT;
            endcase
        end
    end

    assign o_out_valid      = w_emit;
    assign o_out.block_col  = r_s2_bc[5:0];
    assign o_out.block_row  = r_s2_br;
    assign o_out.block_sum  = r_s2_sum;
    assign o_out.status     = w_status;
    assign o_out.last_block = r_s2_lastblk;

    // alarm or fault beat silences the rest of the frame
    a_alarm_mutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !r_s2_frame_end &&
         (o_out.status == ssdmd_pkg::ST_ALARM || o_out.status == ssdmd_pkg::ST_FAULT))
        |=> !o_out_valid)
        else $error("beat after alarm in same frame");

    // forwarded sum only for the column written in the accept cycle
    a_fwd_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!r_s1_fwd || r_s1_item.bc == $past(r_s1_item.bc)))
        else $error("forward to wrong tile column");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_s2_bc < 8'(MAX_BLOCK_COLS)))
        else $error("tile column beyond sum RAM");

endmodule
